@@ rtl/mrpr_pkg.sv @@
// ---------------------------------------------------------------------------
// Miller-Rabin round package
// Shared constants and request/result payload types.
// ---------------------------------------------------------------------------
package mrpr_pkg;

    localparam int NUMBER_BITS_DEFAULT = 63;
    localparam int FIELD_WIDTH = 63;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] candidate;
        logic [FIELD_WIDTH-1:0] witness;
    } mrpr_req_t;

    typedef struct packed {
        logic probably_prime;
        logic screened;
        logic witness_invalid;
    } mrpr_res_t;

endpackage

@@ rtl/miller_rabin_primality_round.sv @@
// ---------------------------------------------------------------------------
// Miller-Rabin primality round
// One request carries a candidate and a witness; one verdict comes back.
// ---------------------------------------------------------------------------
// For screened or invalid requests the strobe follows the serial remainder
// by three. Otherwise up to 2*NUMBER_BITS modular multiplications follow,
// each done by the bit-serial multiplier.
// One request at a time; busy is high meanwhile. The result strobe lasts one
// cycle and cannot be stalled. Reset clears the controller to idle.
module miller_rabin_primality_round
    import mrpr_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  mrpr_req_t request,
    output logic      busy,
    output logic      result_valid,
    output mrpr_res_t result
);

    localparam int CW = $clog2(NUMBER_BITS + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCREEN, ST_STRIP, ST_POW_MUL, ST_POW_WAIT, ST_POW_SQR,
        ST_SQR_WAIT, ST_CHECK, ST_CHAIN_WAIT, ST_DONE
    } state_t;

    state_t                 state_reg;
    logic                   busy_reg;
    logic                   valid_reg;
    mrpr_res_t              result_reg;
    logic [NUMBER_BITS-1:0] n_reg;
    logic [NUMBER_BITS-1:0] w_reg;
    logic [NUMBER_BITS-1:0] m_reg;     // exponent, shifted right while used
    logic [NUMBER_BITS-1:0] d_reg;     // m * 2^r for the squaring chain
    logic [NUMBER_BITS-1:0] x_reg;
    logic [NUMBER_BITS-1:0] b_reg;
    logic [1:0]             mod3_reg;
    logic [CW-1:0]          cnt_reg;

    logic                   mul_go;
    logic [NUMBER_BITS-1:0] mul_a;
    logic [NUMBER_BITS-1:0] mul_b;
    logic                   mul_done;
    logic [NUMBER_BITS-1:0] mul_p;
    logic [1:0]             mod3_next;

    mrpr_mulmod #(.NUMBER_BITS(NUMBER_BITS)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (mul_go),
        .a       (mul_a),
        .b       (mul_b),
        .n       (n_reg),
        .done    (mul_done),
        .product (mul_p)
    );

    // Residue mod 3 built one bit per cycle, from the top bit down.
    always_comb
    begin
        logic [2:0] t;
        t = {mod3_reg, n_reg[cnt_reg[CW-1:0] - 1'b1]};
        mod3_next = (t >= 3'd6) ? 2'(t - 3'd6) : (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
    end

    // Multiplier operands: x * b, b * b, or x * x in the squaring chain.
    assign mul_go = (state_reg == ST_POW_MUL) || (state_reg == ST_POW_SQR)
                 || (state_reg == ST_CHECK && !(x_reg == n_reg - 1'b1)
                     && d_reg <= (n_reg >> 1));
    assign mul_a  = (state_reg == ST_POW_SQR) ? b_reg : x_reg;
    assign mul_b  = (state_reg == ST_CHECK) ? x_reg : b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            busy_reg   <= 1'b0;
            valid_reg  <= 1'b0;
            result_reg <= '0;
            n_reg      <= '0;
            w_reg      <= '0;
            m_reg      <= '0;
            d_reg      <= '0;
            x_reg      <= '0;
            b_reg      <= '0;
            mod3_reg   <= 2'd0;
            cnt_reg    <= '0;
        end
        else
        begin
            valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        n_reg     <= request.candidate[NUMBER_BITS-1:0];
                        w_reg     <= request.witness[NUMBER_BITS-1:0];
                        mod3_reg  <= 2'd0;
                        cnt_reg   <= CW'(NUMBER_BITS);
                        busy_reg  <= 1'b1;
                        state_reg <= ST_SCREEN;
                    end
                end
                // Serial remainder by three.
                ST_SCREEN:
                begin
                    if (cnt_reg != '0)
                    begin
                        mod3_reg <= mod3_next;
                        cnt_reg  <= cnt_reg - 1'b1;
                    end
                    else
                    begin
                        if (n_reg == NUMBER_BITS'(2) || n_reg == NUMBER_BITS'(3))
                        begin
                            result_reg <= '{probably_prime: 1'b1, screened: 1'b1,
                                            witness_invalid: 1'b0};
                            state_reg  <= ST_DONE;
                        end
                        else if (n_reg < NUMBER_BITS'(2) || !n_reg[0] || mod3_reg == 2'd0)
                        begin
                            result_reg <= '{probably_prime: 1'b0, screened: 1'b1,
                                            witness_invalid: 1'b0};
                            state_reg  <= ST_DONE;
                        end
                        else if (w_reg == '0 || w_reg >= n_reg)
                        begin
                            result_reg <= '{probably_prime: 1'b0, screened: 1'b0,
                                            witness_invalid: 1'b1};
                            state_reg  <= ST_DONE;
                        end
                        else
                        begin
                            result_reg <= '0;
                            m_reg      <= (n_reg - 1'b1) >> 1;
                            state_reg  <= ST_STRIP;
                        end
                    end
                end
                // Strip factors of two, one per cycle.
                ST_STRIP:
                begin
                    if (!m_reg[0])
                    begin
                        m_reg <= m_reg >> 1;
                    end
                    else
                    begin
                        d_reg     <= m_reg;
                        x_reg     <= NUMBER_BITS'(1);
                        b_reg     <= w_reg;
                        state_reg <= ST_POW_MUL;
                    end
                end
                // Right-to-left exponentiation: x *= b on a set bit.
                ST_POW_MUL:
                begin
                    state_reg <= ST_POW_WAIT;
                end
                ST_POW_WAIT:
                begin
                    if (mul_done)
                    begin
                        x_reg     <= mul_p;
                        state_reg <= ST_POW_SQR;
                    end
                end
                ST_POW_SQR:
                begin
                    m_reg     <= m_reg >> 1;
                    state_reg <= ST_SQR_WAIT;
                end
                ST_SQR_WAIT:
                begin
                    if (mul_done)
                    begin
                        b_reg <= mul_p;
                        if (m_reg == '0)
                        begin
                            if (x_reg == NUMBER_BITS'(1))
                            begin
                                result_reg.probably_prime <= 1'b1;
                                state_reg                 <= ST_DONE;
                            end
                            else
                            begin
                                state_reg <= ST_CHECK;
                            end
                        end
                        else
                        begin
                            state_reg <= m_reg[0] ? ST_POW_MUL : ST_POW_SQR;
                        end
                    end
                end
                // Squaring chain looking for n-1 while the exponent stays at
                // or below n/2.
                ST_CHECK:
                begin
                    if (d_reg > (n_reg >> 1))
                    begin
                        state_reg <= ST_DONE;
                    end
                    else if (x_reg == n_reg - 1'b1)
                    begin
                        result_reg.probably_prime <= 1'b1;
                        state_reg                 <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_CHAIN_WAIT;
                    end
                end
                ST_CHAIN_WAIT:
                begin
                    if (mul_done)
                    begin
                        x_reg     <= mul_p;
                        d_reg     <= d_reg << 1;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_DONE:
                begin
                    valid_reg <= 1'b1;
                    busy_reg  <= 1'b0;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy         = busy_reg;
    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

@@ rtl/mrpr_mulmod.sv @@
// ---------------------------------------------------------------------------
// Serial modular multiplier
// Computes a * b mod n one bit of b per cycle, most significant bit first.
// ---------------------------------------------------------------------------
module mrpr_mulmod
    import mrpr_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   go,
    input  logic [NUMBER_BITS-1:0] a,
    input  logic [NUMBER_BITS-1:0] b,
    input  logic [NUMBER_BITS-1:0] n,
    output logic                   done,
    output logic [NUMBER_BITS-1:0] product
);

    localparam int CW = $clog2(NUMBER_BITS + 1);

    logic [NUMBER_BITS-1:0] acc_reg;
    logic [NUMBER_BITS-1:0] a_reg;
    logic [NUMBER_BITS-1:0] b_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   run_reg;
    logic                   done_reg;
    logic [NUMBER_BITS:0]   dbl;
    logic [NUMBER_BITS-1:0] dbl_red;
    logic [NUMBER_BITS:0]   sum;
    logic [NUMBER_BITS-1:0] acc_next;

    // Double the accumulator, then add a when the current bit of b is set.
    always_comb
    begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, n}) ? NUMBER_BITS'(dbl - {1'b0, n})
                                     : dbl[NUMBER_BITS-1:0];
        sum     = {1'b0, dbl_red} + {1'b0, a_reg};
        if (b_reg[NUMBER_BITS-1])
        begin
            acc_next = (sum >= {1'b0, n}) ? NUMBER_BITS'(sum - {1'b0, n})
                                          : sum[NUMBER_BITS-1:0];
        end
        else
        begin
            acc_next = dbl_red;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(NUMBER_BITS);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath shift registers; both operands are captured at go.
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
        end
        else if (run_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[NUMBER_BITS-2:0], 1'b0};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule
